### rtl/bmls_pkg.sv
// shared types, constants and codes of the bracket match line scorer
package bmls_pkg;

    // fixed field widths
    localparam int CHAR_W   = 8;
    localparam int PAIR_W   = 2;
    localparam int SCORE_W  = 16;
    localparam int DIGIT_W  = 4;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // parameter defaults
    localparam int STACK_DEPTH_DEFAULT = 16;
    localparam int NUM_PAIRS_DEFAULT   = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPENING_CHARS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSING_CHARS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORRUPT_SCORES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPLETION_DIGITS = 2'd3;

    // configuration reset values
    localparam logic [31:0] OPENING_CHARS_RST     = 32'd1014717224;
    localparam logic [31:0] CLOSING_CHARS_RST     = 32'd1048403241;
    localparam logic [63:0] CORRUPT_SCORES_RST    = 64'd0;
    localparam logic [15:0] COMPLETION_DIGITS_RST = 16'd17185;

    // line status codes
    localparam logic [STATUS_W-1:0] LS_BALANCED   = 3'd0;
    localparam logic [STATUS_W-1:0] LS_CORRUPT    = 3'd1;
    localparam logic [STATUS_W-1:0] LS_INCOMPLETE = 3'd2;
    localparam logic [STATUS_W-1:0] LS_UNKNOWN    = 3'd3;
    localparam logic [STATUS_W-1:0] LS_OVERFLOW   = 3'd4;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN
    } bmls_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load_item;
        logic exec;
        logic drain_step;
        logic finish;
    } bmls_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic item_last;
        logic drain_needed;
        logic out_free;
    } bmls_status_t;

endpackage

### rtl/bmls_ctrl.sv
// controller state machine of the bracket match line scorer
module bmls_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  bmls_pkg::bmls_status_t status,
    output bmls_pkg::bmls_cmd_t    cmd
);

    bmls_pkg::bmls_state_t state_reg;
    bmls_pkg::bmls_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmls_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            bmls_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = bmls_pkg::ST_EXEC;
                end
            end
            bmls_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.item_last ? bmls_pkg::ST_DRAIN : bmls_pkg::ST_IDLE;
            end
            bmls_pkg::ST_DRAIN:
            begin
                if (status.drain_needed)
                begin
                    cmd.drain_step = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = bmls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmls_pkg::ST_IDLE;
            end
        endcase
    end

    // a word is executed only right after it was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> $past(cmd.load_item))
        else $error("exec without a loaded word");

    // the stack is drained before a result is produced
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !status.drain_needed && status.out_free)
        else $error("finish while drain pending or output busy");

    // commands are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_item, cmd.exec, cmd.drain_step, cmd.finish}))
        else $error("overlapping commands");

endmodule

### rtl/bmls_dp.sv
// datapath of the bracket match line scorer: config, stack, scores, output register
module bmls_dp
#(
    parameter int STACK_DEPTH = bmls_pkg::STACK_DEPTH_DEFAULT,
    parameter int NUM_PAIRS   = bmls_pkg::NUM_PAIRS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [bmls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmls_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input word
    input  logic [bmls_pkg::CHAR_W-1:0]        char_code,
    input  logic                               char_present,
    input  logic                               last_of_line,
    // output word
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [bmls_pkg::STATUS_W-1:0]      line_status,
    output logic [bmls_pkg::SCORE_W-1:0]       line_corrupt_score,
    output logic [bmls_pkg::TOTAL_W-1:0]       completion_score,
    output logic [bmls_pkg::TOTAL_W-1:0]       corrupt_total,
    // control
    input  bmls_pkg::bmls_cmd_t                cmd,
    output bmls_pkg::bmls_status_t             status
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // configuration registers
    logic [31:0] opening_chars_reg;
    logic [31:0] closing_chars_reg;
    logic [63:0] corrupt_scores_reg;
    logic [15:0] completion_digits_reg;

    // captured word
    logic [bmls_pkg::CHAR_W-1:0] char_reg;
    logic                        present_reg;
    logic                        last_reg;

    // line state
    logic [bmls_pkg::PAIR_W-1:0]   stack_reg [STACK_DEPTH];
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [bmls_pkg::STATUS_W-1:0] fault_reg;
    logic [bmls_pkg::STATUS_W-1:0] fault_next;
    logic [bmls_pkg::SCORE_W-1:0]  latched_reg;
    logic [bmls_pkg::SCORE_W-1:0]  latched_next;
    logic                          incomplete_reg;
    logic [bmls_pkg::TOTAL_W-1:0]  completion_reg;
    logic [bmls_pkg::TOTAL_W-1:0]  total_reg;

    // output register
    logic                          out_valid_reg;
    logic [bmls_pkg::STATUS_W-1:0] status_out_reg;
    logic [bmls_pkg::SCORE_W-1:0]  score_out_reg;
    logic [bmls_pkg::TOTAL_W-1:0]  completion_out_reg;
    logic [bmls_pkg::TOTAL_W-1:0]  total_out_reg;

    // decode of the character
    logic                          closer_hit;
    logic                          opener_hit;
    logic [bmls_pkg::PAIR_W-1:0]   closer_pair;
    logic [bmls_pkg::PAIR_W-1:0]   opener_pair;
    logic [IDX_W-1:0]              top_idx;
    logic [IDX_W-1:0]              push_idx;
    logic [bmls_pkg::PAIR_W-1:0]   top_pair;
    logic [bmls_pkg::CHAR_W-1:0]   top_closer;
    logic [bmls_pkg::DIGIT_W-1:0]  top_digit;
    logic                          push_en;
    logic [bmls_pkg::TOTAL_W-1:0]  total_sum;
    logic [bmls_pkg::STATUS_W-1:0] final_status;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opening_chars_reg     <= bmls_pkg::OPENING_CHARS_RST;
            closing_chars_reg     <= bmls_pkg::CLOSING_CHARS_RST;
            corrupt_scores_reg    <= bmls_pkg::CORRUPT_SCORES_RST;
            completion_digits_reg <= bmls_pkg::COMPLETION_DIGITS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bmls_pkg::CFG_OPENING_CHARS:     opening_chars_reg     <= cfg_data[31:0];
                bmls_pkg::CFG_CLOSING_CHARS:     closing_chars_reg     <= cfg_data[31:0];
                bmls_pkg::CFG_CORRUPT_SCORES:    corrupt_scores_reg    <= cfg_data;
                bmls_pkg::CFG_COMPLETION_DIGITS: completion_digits_reg <= cfg_data[15:0];
            endcase
        end
    end

    // lowest matching pair for closer and opener
    always_comb
    begin
        closer_hit  = 1'b0;
        opener_hit  = 1'b0;
        closer_pair = '0;
        opener_pair = '0;
        for (int p = NUM_PAIRS - 1; p >= 0; p--)
        begin
            if (closing_chars_reg[8*p +: 8] == char_reg)
            begin
                closer_hit  = 1'b1;
                closer_pair = bmls_pkg::PAIR_W'(p);
            end
            if (opening_chars_reg[8*p +: 8] == char_reg)
            begin
                opener_hit  = 1'b1;
                opener_pair = bmls_pkg::PAIR_W'(p);
            end
        end
    end

    // stack top lookups
    always_comb
    begin
        logic [CNT_W-1:0] top_cnt;
        top_cnt    = count_reg - 1'b1;
        top_idx    = top_cnt[IDX_W-1:0];
        push_idx   = count_reg[IDX_W-1:0];
        top_pair   = stack_reg[top_idx];
        top_closer = closing_chars_reg[{top_pair, 3'b000} +: bmls_pkg::CHAR_W];
        top_digit  = completion_digits_reg[{top_pair, 2'b00} +: bmls_pkg::DIGIT_W];
    end

    // character step
    always_comb
    begin
        count_next   = count_reg;
        fault_next   = fault_reg;
        latched_next = latched_reg;
        push_en      = 1'b0;
        if (present_reg && (fault_reg == bmls_pkg::LS_BALANCED))
        begin
            if (closer_hit)
            begin
                if ((count_reg != '0) && (top_closer == char_reg))
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    fault_next   = bmls_pkg::LS_CORRUPT;
                    latched_next = corrupt_scores_reg[{closer_pair, 4'b0000} +: bmls_pkg::SCORE_W];
                    count_next   = '0;
                end
            end
            else if (opener_hit)
            begin
                if (count_reg >= CNT_W'(STACK_DEPTH))
                begin
                    fault_next = bmls_pkg::LS_OVERFLOW;
                end
                else
                begin
                    push_en    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                fault_next = bmls_pkg::LS_UNKNOWN;
            end
        end
    end

    // result of the line
    always_comb
    begin
        total_sum = total_reg + bmls_pkg::TOTAL_W'(latched_reg);
        if (fault_reg != bmls_pkg::LS_BALANCED)
        begin
            final_status = fault_reg;
        end
        else if (incomplete_reg)
        begin
            final_status = bmls_pkg::LS_INCOMPLETE;
        end
        else
        begin
            final_status = bmls_pkg::LS_BALANCED;
        end
    end

    // stack storage, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_en)
        begin
            stack_reg[push_idx] <= opener_pair;
        end
    end

    // captured word
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            char_reg    <= char_code;
            present_reg <= char_present;
            last_reg    <= last_of_line;
        end
    end

    // line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            fault_reg      <= bmls_pkg::LS_BALANCED;
            latched_reg    <= '0;
            incomplete_reg <= 1'b0;
            completion_reg <= '0;
            total_reg      <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg   <= count_next;
            fault_reg   <= fault_next;
            latched_reg <= latched_next;
        end
        else if (cmd.drain_step)
        begin
            // score = 5 * score + digit, walking down from the top
            completion_reg <= (completion_reg << 2) + completion_reg
                              + bmls_pkg::TOTAL_W'(top_digit);
            count_reg      <= count_reg - 1'b1;
            incomplete_reg <= 1'b1;
        end
        else if (cmd.finish)
        begin
            count_reg      <= '0;
            fault_reg      <= bmls_pkg::LS_BALANCED;
            latched_reg    <= '0;
            incomplete_reg <= 1'b0;
            completion_reg <= '0;
            total_reg      <= total_sum;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_out_reg     <= final_status;
            score_out_reg      <= latched_reg;
            completion_out_reg <= completion_reg;
            total_out_reg      <= total_sum;
        end
    end

    // status to controller
    always_comb
    begin
        status.item_last    = last_reg;
        status.drain_needed = (fault_reg == bmls_pkg::LS_BALANCED) && (count_reg != '0);
        status.out_free     = !out_valid_reg || !out_stall;
    end

    assign out_valid          = out_valid_reg;
    assign line_status        = status_out_reg;
    assign line_corrupt_score = score_out_reg;
    assign completion_score   = completion_out_reg;
    assign corrupt_total      = total_out_reg;

    // the stack never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // a finished line leaves an empty stack and no fault
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (count_reg == '0) && (fault_reg == bmls_pkg::LS_BALANCED))
        else $error("line state not cleared");

    // a pending word is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.finish)
        else $error("output word overwritten");

    // a corrupt score is only latched together with the corrupt status
    assert property (@(posedge clk) disable iff (!rst_n)
        (latched_reg != '0) |-> (fault_reg == bmls_pkg::LS_CORRUPT))
        else $error("score latched without corrupt status");

endmodule

### rtl/bracket_match_line_scorer_core.sv
// top level of the bracket match line scorer
//
//  channel   signals                                              direction
//  in        in_valid, in_stall, char_code, char_present,         into block
//            last_of_line
//  out       out_valid, out_stall, line_status,                   out of block
//            line_corrupt_score, completion_score, corrupt_total
//  cfg       cfg_we, cfg_index, cfg_data                          into block
//
//  a character word is accepted, then executed: at most one push or pop of the stack
//  after a last word, a line without fault pops every stack entry to build
//  the completion score (one multiply-by-5-and-add per cycle), then loads
//  the output register, which may wait while out_stall holds a previous word
//  rst_n clears control and the line state; stack entries are not cleared
//  in_stall is low only while the block waits for a new word
module bracket_match_line_scorer_core
#(
    parameter int STACK_DEPTH = bmls_pkg::STACK_DEPTH_DEFAULT,
    parameter int NUM_PAIRS   = bmls_pkg::NUM_PAIRS_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [bmls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmls_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [bmls_pkg::CHAR_W-1:0]        char_code,
    input  logic                               char_present,
    input  logic                               last_of_line,
    // output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [bmls_pkg::STATUS_W-1:0]      line_status,
    output logic [bmls_pkg::SCORE_W-1:0]       line_corrupt_score,
    output logic [bmls_pkg::TOTAL_W-1:0]       completion_score,
    output logic [bmls_pkg::TOTAL_W-1:0]       corrupt_total
);

    bmls_pkg::bmls_cmd_t    cmd;
    bmls_pkg::bmls_status_t status;

    // controller
    bmls_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    bmls_dp
    #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_PAIRS   (NUM_PAIRS)
    )
    u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .char_code          (char_code),
        .char_present       (char_present),
        .last_of_line       (last_of_line),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .line_status        (line_status),
        .line_corrupt_score (line_corrupt_score),
        .completion_score   (completion_score),
        .corrupt_total      (corrupt_total),
        .cmd                (cmd),
        .status             (status)
    );

endmodule
